// File: rtl/terminal_line_editor_unit_assert.svh
// Assertion macros shared by the line editor modules.
`ifndef TERMINAL_LINE_EDITOR_UNIT_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tle_pkg.sv
// Package: sizes, byte codes and shared types of the line editor.
package tle_pkg;

   localparam int LINE_MAX = 64;
   localparam int ADDR_W   = $clog2(LINE_MAX);
   localparam int CURSOR_W = $clog2(LINE_MAX + 1);
   localparam int LEN_W    = 7;

   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RIGHT    = 8'h43;
   localparam logic [7:0] CH_LEFT     = 8'h44;
   localparam logic [7:0] PRINT_LO    = 8'h20;
   localparam logic [7:0] PRINT_HI    = 8'h7E;

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ESC,
      PH_CSI
   } phase_type;

   typedef enum logic {
      ST_EDIT,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic take;    // byte word accepted, apply edit
      logic start;   // line complete, begin read-out at column 0
      logic next;    // character word taken, read the next column
      logic finish;  // last word taken, clear the line
   } cmd_type;

   typedef struct packed {
      logic line_end;  // current byte is LF after CR
      logic last;      // word on the output is the final one of the line
   } status_type;

endpackage

// File: rtl/tle_ifs.sv
// Valid/ready channel interfaces for byte input and line output.
interface tle_req_if;
   import tle_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_rsp_if;
   import tle_pkg::*;
   logic             valid;
   logic             ready;
   logic [7:0]       line_char;
   logic [LEN_W-1:0] line_length;
   logic             last;

   modport source (output valid, output line_char, output line_length, output last,
                   input ready);
   modport sink   (input valid, input line_char, input line_length, input last,
                   output ready);
endinterface

// File: rtl/terminal_line_editor_unit.sv
// Top level of the serial console line editor.
//
// req_if carries raw console bytes (rx_byte), one word per valid/ready handshake.
// Printable bytes go into a line store at the cursor; backspace and ESC [ C / D
// move the cursor; other ESC [ final bytes and control bytes are dropped.
// rsp_if carries the finished line, one word per character (line_char,
// line_length, last), or one zero word with length 0 for an empty line.
// Throughput: one input byte per cycle while editing; the line store takes
// one write per cycle through its write port.
// The first output word is valid the cycle after the LF of a CR LF pair is
// accepted; further words follow one per cycle while the receiver is ready, set
// by the registered read of the line store.
// While a line is read out req_if.ready is low, also while the receiver stalls,
// and input reopens the cycle after the last word is taken.
// A stalled receiver holds the current word steady until taken.
// Reset (synchronous, active high) clears the cursor, escape state and the
// per-column valid bits at once, so the store reads as all zeros; no
// clearing pass is needed. The same happens after every emitted line.
module terminal_line_editor_unit
   import tle_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tle_req_if.sink   req_if,
   tle_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;

   // state machine: edit mode versus read-out
   tle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // cursor, escape filter, line store and output word
   tle_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rx_byte     (req_if.rx_byte),
      .status      (status),
      .line_char   (rsp_if.line_char),
      .line_length (rsp_if.line_length),
      .last        (rsp_if.last)
   );

endmodule

// File: rtl/tle_ctrl.sv
// Controller: sequences between line editing and line read-out.
module tle_ctrl
   import tle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

`include "terminal_line_editor_unit_assert.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EDIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_EDIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.line_end) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SEND;
               end
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_EDIT;
               end else begin
                  cmd.next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_EDIT;
         end
      endcase
   end

   `TLE_ASSERT(a_no_overlap, !(req_ready && rsp_valid), "input and output open together")
   `TLE_ASSERT_NEXT(a_start_sends, cmd.start, rsp_valid, "line end did not start read-out")
   `TLE_ASSERT_NEXT(a_more_words, rsp_valid && rsp_ready && !status.last, rsp_valid,
                    "read-out stopped before last word")

endmodule

// File: rtl/tle_datapath.sv
// Datapath: escape decode, cursor, line store and read-out registers.
module tle_datapath
   import tle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [7:0]       rx_byte,
   output status_type       status,
   output logic [7:0]       line_char,
   output logic [LEN_W-1:0] line_length,
   output logic             last
);

`include "terminal_line_editor_unit_assert.svh"

   logic [7:0]          mem [LINE_MAX];
   logic [LINE_MAX-1:0] valid_ff, valid_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   phase_type           phase_ff, phase_in;
   logic                cr_ff, cr_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [7:0]          rd_data_ff;
   logic                rd_vld_ff;

   logic                edit;
   logic                wr_en;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CURSOR_W-1:0] idx_plus;
   logic                printable;
   logic                not_full;
   logic                not_zero;

   assign printable = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);
   assign not_full  = cursor_ff < CURSOR_W'(LINE_MAX);
   assign not_zero  = cursor_ff != '0;
   assign idx_plus  = CURSOR_W'({1'b0, idx_ff}) + CURSOR_W'(1);

   // Escape phase never coexists with a pending CR, so only CSI is excluded.
   assign status.line_end = (phase_ff != PH_CSI) && (rx_byte == CH_LF) && cr_ff;
   assign status.last     = !not_zero || (idx_plus == cursor_ff);

   assign edit = cmd.take && !cmd.start;

   always_comb begin
      cursor_in = cursor_ff;
      phase_in  = phase_ff;
      cr_in     = cr_ff;
      valid_in  = valid_ff;
      wr_en     = 1'b0;
      if (cmd.finish) begin
         cursor_in = '0;
         phase_in  = PH_NORMAL;
         cr_in     = 1'b0;
         valid_in  = '0;
      end else if (edit) begin
         if (phase_ff == PH_CSI) begin
            phase_in = PH_NORMAL;
            cr_in    = 1'b0;
            if (rx_byte == CH_RIGHT && not_full) begin
               cursor_in = cursor_ff + CURSOR_W'(1);
            end else if (rx_byte == CH_LEFT && not_zero) begin
               cursor_in = cursor_ff - CURSOR_W'(1);
            end
         end else if (phase_ff == PH_ESC && rx_byte == CH_LBRACKET) begin
            phase_in = PH_CSI;
            cr_in    = 1'b0;
         end else begin
            // normal byte handling, also for the byte after a lone ESC
            cr_in    = (rx_byte == CH_CR);
            phase_in = (rx_byte == CH_ESC) ? PH_ESC : PH_NORMAL;
            if (printable) begin
               if (not_full) begin
                  wr_en     = 1'b1;
                  valid_in[cursor_ff[ADDR_W-1:0]] = 1'b1;
                  cursor_in = cursor_ff + CURSOR_W'(1);
               end
            end else if (rx_byte == CH_BS && not_zero) begin
               cursor_in = cursor_ff - CURSOR_W'(1);
            end
         end
      end
   end

   assign rd_en   = cmd.start || cmd.next;
   assign rd_addr = cmd.start ? '0 : idx_plus[ADDR_W-1:0];
   assign idx_in  = cmd.start ? '0 : (cmd.next ? idx_plus[ADDR_W-1:0] : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         phase_ff  <= PH_NORMAL;
         cr_ff     <= 1'b0;
         valid_ff  <= '0;
      end else begin
         cursor_ff <= cursor_in;
         phase_ff  <= phase_in;
         cr_ff     <= cr_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (wr_en) begin
         mem[cursor_ff[ADDR_W-1:0]] <= rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   // unwritten columns read as zero; an empty line gives a zero word
   assign line_char   = (not_zero && rd_vld_ff) ? rd_data_ff : 8'h00;
   assign line_length = LEN_W'(cursor_ff);
   assign last        = status.last;

   `TLE_ASSERT(a_cursor_range, cursor_ff <= CURSOR_W'(LINE_MAX), "cursor beyond line")
   `TLE_ASSERT_NEXT(a_cleared, cmd.finish, cursor_ff == '0 && valid_ff == '0,
                    "line not cleared after read-out")
   `TLE_ASSERT(a_no_edit_in_readout, !(cmd.take && (cmd.next || cmd.finish)),
               "edit during read-out")

endmodule
